### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the buddy page allocator.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define BPA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Clocked check that also holds during reset.
`define BPA_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

### hw/rtl/bpa_pkg.sv
// Shared constants, codes and controller/datapath types of the buddy page allocator.
// No dependencies.
package bpa_pkg;

   localparam int unsigned NUM_PAGES_DEF = 16384;
   localparam int unsigned TOP_ORDER_DEF = 10;
   localparam int PAGE_W_DEF = $clog2(NUM_PAGES_DEF);

   localparam int ORDER_W   = 4;
   localparam int ACT_W     = 2;
   localparam int STAT_W    = 2;
   localparam int CFG_W     = 5;
   localparam int CFG_IDX_W = 1;
   localparam int CNT_W     = 15;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // action codes
   localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
   localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
   localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

   // configuration register indexes and reset values
   localparam logic [CFG_IDX_W-1:0] CSR_TOTAL_BLOCKS  = 1'b0;
   localparam logic [CFG_IDX_W-1:0] CSR_KERNEL_BLOCKS = 1'b1;
   localparam logic [CFG_W-1:0] TOTAL_RST  = 5'd16;
   localparam logic [CFG_W-1:0] KERNEL_RST = 5'd4;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_FILL,
      CMD_FIND,
      CMD_POP_RD,
      CMD_POP_WR,
      CMD_TOG_RD,
      CMD_TOG_WR,
      CMD_SPLIT,
      CMD_UNLINK,
      CMD_PUSH,
      CMD_PUBLISH
   } dp_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             bad;
      logic             found;
      logic             below_top;
      logic             split_more;
      logic             tog_new;
      logic             clr_last;
      logic             fill_done;
   } dp_stat_type;

endpackage

### hw/rtl/bpa_req_if.sv
// Request channel of the buddy page allocator: valid/ready plus one item.
// Depends on bpa_pkg.
interface bpa_req_if #(parameter int PAGE_W = bpa_pkg::PAGE_W_DEF) ();
   import bpa_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic                pool_sel;
   logic [ORDER_W-1:0]  block_order;
   logic [PAGE_W-1:0]   page_index;

   modport source (output valid, action, pool_sel, block_order, page_index, input ready);
   modport sink   (input valid, action, pool_sel, block_order, page_index, output ready);
endinterface

### hw/rtl/bpa_rsp_if.sv
// Response channel of the buddy page allocator: valid/ready plus one result.
// Depends on bpa_pkg.
interface bpa_rsp_if #(parameter int PAGE_W = bpa_pkg::PAGE_W_DEF) ();
   import bpa_pkg::*;

   logic                valid;
   logic                ready;
   logic [PAGE_W-1:0]   granted_page;
   logic [STAT_W-1:0]   status;

   modport source (output valid, granted_page, status, input ready);
   modport sink   (input valid, granted_page, status, output ready);
endinterface

### hw/rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
   parameter int WIDTH  = 1,
   parameter int DEPTH  = 2,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### hw/rtl/bpa_dp.sv
// Datapath of the buddy page allocator: config, free-list registers, link and
// pair-bit RAMs, item registers and result register. Depends on bpa_pkg, bpa_ram.
module bpa_dp #(
   parameter int unsigned NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
   parameter int unsigned TOP_ORDER = bpa_pkg::TOP_ORDER_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bpa_pkg::dp_cmd_type               cmd,
   output bpa_pkg::dp_stat_type              stat,
   input  logic                              csr_we,
   input  logic [bpa_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [bpa_pkg::CFG_W-1:0]         csr_wdata,
   input  logic [bpa_pkg::ACT_W-1:0]         req_action,
   input  logic                              req_pool_sel,
   input  logic [bpa_pkg::ORDER_W-1:0]       req_block_order,
   input  logic [$clog2(NUM_PAGES)-1:0]      req_page_index,
   output logic [$clog2(NUM_PAGES)-1:0]      rsp_granted_page,
   output logic [bpa_pkg::STAT_W-1:0]        rsp_status
);
   import bpa_pkg::*;

   localparam int PAGE_W    = $clog2(NUM_PAGES);
   localparam int NUM_LISTS = 2 * (TOP_ORDER + 1);
   localparam int LIST_W    = $clog2(NUM_LISTS);
   localparam int BLK_W     = PAGE_W - TOP_ORDER;
   localparam int CMP_W     = ((BLK_W > CFG_W) ? BLK_W : CFG_W) + 1;
   localparam int unsigned LIM = NUM_PAGES >> TOP_ORDER;
   localparam logic [LIST_W-1:0]  USER_BASE = LIST_W'(TOP_ORDER + 1);
   localparam logic [ORDER_W-1:0] TOP_O     = ORDER_W'(TOP_ORDER);
   localparam logic [PAGE_W:0]    NP_EXT    = (PAGE_W+1)'(NUM_PAGES);

   // configuration
   logic [CFG_W-1:0] total_ff, total_in, kernel_ff, kernel_in;
   logic [CFG_W-1:0] tb_cl, kb_cl;

   // item registers
   logic [ACT_W-1:0]   act_ff, act_in;
   logic [STAT_W-1:0]  status_ff, status_in;
   logic [PAGE_W-1:0]  granted_ff, granted_in;
   logic [PAGE_W-1:0]  idx_ff, idx_in;
   logic [ORDER_W-1:0] order_ff, order_in;
   logic [ORDER_W-1:0] o_ff, o_in;
   logic [LIST_W-1:0]  base_ff, base_in;
   logic [PAGE_W-1:0]  pos_ff;
   logic [PAGE_W-1:0]  clr_ff, clr_in;
   logic [CFG_W-1:0]   blk_ff, blk_in;
   logic [PAGE_W-1:0]  out_page_ff;
   logic [STAT_W-1:0]  out_status_ff;

   // free-list registers
   logic [PAGE_W-1:0] head_ff [NUM_LISTS];
   logic [PAGE_W-1:0] head_in [NUM_LISTS];
   logic [PAGE_W-1:0] tail_ff [NUM_LISTS];
   logic [PAGE_W-1:0] tail_in [NUM_LISTS];
   logic [CNT_W-1:0]  cnt_ff  [NUM_LISTS];
   logic [CNT_W-1:0]  cnt_in  [NUM_LISTS];

   // RAM ports
   logic              next_we, prev_we, pair_we;
   logic [PAGE_W-1:0] next_waddr, next_wdata, next_raddr, next_rdata;
   logic [PAGE_W-1:0] prev_waddr, prev_wdata, prev_raddr, prev_rdata;
   logic [PAGE_W-1:0] pair_waddr, pair_raddr;
   logic              pair_wdata, pair_rdata;

   // working values
   logic [PAGE_W-1:0]  req_blk, order_mask;
   logic               order_bad, page_bad, free_user;
   logic [STAT_W-1:0]  load_status;
   logic [LIST_W-1:0]  load_base;
   logic [ORDER_W-1:0] o_eff;
   logic [LIST_W-1:0]  lsel;
   logic [PAGE_W-1:0]  cur_head, cur_tail;
   logic [CNT_W-1:0]   cur_cnt, cnt_up, cnt_down;
   logic               cnt_nz;
   logic [PAGE_W-1:0]  buddy, half, fill_page, push_n;
   logic [PAGE_W:0]    pos_off;
   logic [PAGE_W-1:0]  pos;
   logic               found;
   logic [ORDER_W-1:0] found_o;

   bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_next_ram (
      .clock(clock), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
      .raddr(next_raddr), .rdata(next_rdata)
   );

   bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_prev_ram (
      .clock(clock), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
      .raddr(prev_raddr), .rdata(prev_rdata)
   );

   bpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_pair_ram (
      .clock(clock), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
      .raddr(pair_raddr), .rdata(pair_rdata)
   );

   // clamp the pool sizes, in max-order blocks
   assign tb_cl = (32'(total_ff) > LIM) ? CFG_W'(LIM) : total_ff;
   assign kb_cl = (kernel_ff > tb_cl) ? tb_cl : kernel_ff;

   // request checks
   assign req_blk    = req_page_index >> TOP_ORDER;
   assign order_mask = (PAGE_W'(1) << req_block_order) - PAGE_W'(1);
   assign order_bad  = req_block_order > TOP_O;
   assign page_bad   = order_bad || (CMP_W'(req_blk) >= CMP_W'(tb_cl))
                       || ((req_page_index & order_mask) != '0);
   assign free_user  = CMP_W'(req_blk) >= CMP_W'(kb_cl);

   always_comb begin
      unique case (req_action)
         ACT_ALLOC: begin
            load_status = order_bad ? ST_BAD : ST_OK;
            load_base   = req_pool_sel ? USER_BASE : '0;
         end
         ACT_FREE: begin
            load_status = page_bad ? ST_BAD : ST_OK;
            load_base   = free_user ? USER_BASE : '0;
         end
         default: begin
            load_status = ST_OK;
            load_base   = '0;
         end
      endcase
   end

   // split works one order below the current one
   assign o_eff = (cmd == CMD_SPLIT) ? (o_ff - ORDER_W'(1)) : o_ff;

   always_comb begin
      if (cmd == CMD_FILL) begin
         lsel = (blk_ff < kb_cl) ? LIST_W'(TOP_ORDER) : (USER_BASE + LIST_W'(TOP_ORDER));
      end else begin
         lsel = base_ff + LIST_W'(o_eff);
      end
   end

   assign cur_head = head_ff[lsel];
   assign cur_tail = tail_ff[lsel];
   assign cur_cnt  = cnt_ff[lsel];
   assign cnt_nz   = cur_cnt != '0;
   assign cnt_up   = (cur_cnt != CNT_MAX) ? (cur_cnt + CNT_W'(1)) : cur_cnt;
   assign cnt_down = cnt_nz ? (cur_cnt - CNT_W'(1)) : cur_cnt;

   assign buddy     = idx_ff ^ (PAGE_W'(1) << o_ff);
   assign half      = idx_ff + (PAGE_W'(1) << o_eff);
   assign fill_page = PAGE_W'(blk_ff) << TOP_ORDER;
   assign push_n    = (cmd == CMD_FILL) ? fill_page : half;

   // pair bits are packed order by order
   assign pos_off = NP_EXT - (NP_EXT >> o_eff);
   assign pos     = pos_off[PAGE_W-1:0] + (idx_ff >> ({1'b0, o_eff} + 5'd1));

   // smallest non-empty list at or above the requested order
   always_comb begin
      found   = 1'b0;
      found_o = o_ff;
      for (int k = TOP_ORDER; k >= 0; k--) begin
         if ((ORDER_W'(k) >= order_ff) && (cnt_ff[base_ff + LIST_W'(k)] != '0)) begin
            found   = 1'b1;
            found_o = ORDER_W'(k);
         end
      end
   end

   // RAM access
   always_comb begin
      next_we    = 1'b0;
      next_waddr = cur_tail;
      next_wdata = push_n;
      next_raddr = buddy;
      prev_we    = 1'b0;
      prev_waddr = push_n;
      prev_wdata = cur_tail;
      prev_raddr = buddy;
      pair_we    = 1'b0;
      pair_waddr = pos_ff;
      pair_wdata = ~pair_rdata;
      pair_raddr = pos;
      unique case (cmd)
         CMD_FILL, CMD_SPLIT: begin
            next_we = cnt_nz;
            prev_we = cnt_nz;
         end
         CMD_POP_RD: begin
            next_raddr = cur_head;
         end
         CMD_PUSH: begin
            next_we    = cnt_nz;
            next_waddr = idx_ff;
            next_wdata = cur_head;
            prev_we    = cnt_nz;
            prev_waddr = cur_head;
            prev_wdata = idx_ff;
         end
         CMD_UNLINK: begin
            next_we    = cnt_nz && (buddy != cur_head);
            next_waddr = prev_rdata;
            next_wdata = next_rdata;
            prev_we    = cnt_nz && (buddy != cur_tail);
            prev_waddr = next_rdata;
            prev_wdata = prev_rdata;
         end
         CMD_CLEAR: begin
            pair_we    = 1'b1;
            pair_waddr = clr_ff;
            pair_wdata = 1'b0;
         end
         CMD_TOG_WR: begin
            pair_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // next values
   always_comb begin
      total_in   = total_ff;
      kernel_in  = kernel_ff;
      act_in     = act_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      idx_in     = idx_ff;
      order_in   = order_ff;
      o_in       = o_ff;
      base_in    = base_ff;
      clr_in     = clr_ff;
      blk_in     = blk_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      cnt_in     = cnt_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TOTAL_BLOCKS:  total_in  = csr_wdata;
            CSR_KERNEL_BLOCKS: kernel_in = csr_wdata;
            default: begin
            end
         endcase
      end

      unique case (cmd)
         CMD_LOAD: begin
            act_in     = req_action;
            idx_in     = req_page_index;
            order_in   = req_block_order;
            o_in       = req_block_order;
            base_in    = load_base;
            status_in  = load_status;
            granted_in = '0;
            clr_in     = '0;
            blk_in     = '0;
         end
         CMD_CLEAR: begin
            clr_in = clr_ff + PAGE_W'(1);
            for (int i = 0; i < NUM_LISTS; i++) begin
               head_in[i] = '0;
               tail_in[i] = '0;
               cnt_in[i]  = '0;
            end
         end
         CMD_FILL, CMD_SPLIT: begin
            if (!cnt_nz) begin
               head_in[lsel] = push_n;
            end
            tail_in[lsel] = push_n;
            cnt_in[lsel]  = cnt_up;
            if (cmd == CMD_FILL) begin
               blk_in = blk_ff + CFG_W'(1);
            end else begin
               o_in = o_eff;
            end
         end
         CMD_FIND: begin
            o_in      = found_o;
            status_in = found ? ST_OK : ST_OOM;
         end
         CMD_POP_RD: begin
            idx_in       = cur_head;
            cnt_in[lsel] = cnt_down;
         end
         CMD_POP_WR: begin
            head_in[lsel] = next_rdata;
            granted_in    = idx_ff;
         end
         CMD_UNLINK: begin
            if (cnt_nz) begin
               if (buddy == cur_head) begin
                  head_in[lsel] = next_rdata;
               end
               if (buddy == cur_tail) begin
                  tail_in[lsel] = prev_rdata;
               end
               cnt_in[lsel] = cnt_down;
            end
            idx_in = idx_ff & ~(PAGE_W'(1) << o_ff);
            o_in   = o_ff + ORDER_W'(1);
         end
         CMD_PUSH: begin
            if (!cnt_nz) begin
               tail_in[lsel] = idx_ff;
            end
            head_in[lsel] = idx_ff;
            cnt_in[lsel]  = cnt_up;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= TOTAL_RST;
         kernel_ff <= KERNEL_RST;
         clr_ff    <= '0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         total_ff  <= total_in;
         kernel_ff <= kernel_in;
         clr_ff    <= clr_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      idx_ff     <= idx_in;
      order_ff   <= order_in;
      o_ff       <= o_in;
      base_ff    <= base_in;
      blk_ff     <= blk_in;
      pos_ff     <= pos;
      if (cmd == CMD_PUBLISH) begin
         out_page_ff   <= granted_ff;
         out_status_ff <= status_ff;
      end
   end

   assign rsp_granted_page = out_page_ff;
   assign rsp_status       = out_status_ff;

   assign stat.action     = act_ff;
   assign stat.bad        = status_ff == ST_BAD;
   assign stat.found      = found;
   assign stat.below_top  = o_ff < TOP_O;
   assign stat.split_more = o_ff > order_ff;
   assign stat.tog_new    = ~pair_rdata;
   assign stat.clr_last   = clr_ff == {PAGE_W{1'b1}};
   assign stat.fill_done  = blk_ff == tb_cl;
endmodule

### hw/rtl/bpa_ctrl.sv
// Controller of the buddy page allocator: sequences init, alloc and free steps
// and owns the channel handshakes. Depends on bpa_pkg.
module bpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bpa_pkg::dp_cmd_type   cmd,
   input  bpa_pkg::dp_stat_type  stat
);
   import bpa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_INIT_CLR,
      S_FILL,
      S_FIND,
      S_POP_RD,
      S_POP_WR,
      S_TOG_WR_A,
      S_SPLIT,
      S_TOG_RD_F,
      S_TOG_WR_F,
      S_UNLINK,
      S_PUSH,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = CMD_NOP;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd = CMD_CLEAR;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.action)
               ACT_INIT:  state_in = S_INIT_CLR;
               ACT_ALLOC: state_in = stat.bad ? S_FINISH : S_FIND;
               ACT_FREE:  state_in = stat.bad ? S_FINISH : S_TOG_RD_F;
               default:   state_in = S_FINISH;
            endcase
         end
         S_INIT_CLR: begin
            cmd = CMD_CLEAR;
            if (stat.clr_last) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (stat.fill_done) begin
               state_in = S_FINISH;
            end else begin
               cmd = CMD_FILL;
            end
         end
         S_FIND: begin
            cmd      = CMD_FIND;
            state_in = stat.found ? S_POP_RD : S_FINISH;
         end
         S_POP_RD: begin
            cmd      = CMD_POP_RD;
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            cmd = CMD_POP_WR;
            priority if (stat.below_top) begin
               state_in = S_TOG_WR_A;
            end else if (stat.split_more) begin
               state_in = S_SPLIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_TOG_WR_A: begin
            cmd      = CMD_TOG_WR;
            state_in = stat.split_more ? S_SPLIT : S_FINISH;
         end
         S_SPLIT: begin
            cmd      = CMD_SPLIT;
            state_in = S_TOG_WR_A;
         end
         S_TOG_RD_F: begin
            if (stat.below_top) begin
               cmd      = CMD_TOG_RD;
               state_in = S_TOG_WR_F;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_TOG_WR_F: begin
            // pair bit back to zero: the buddy is free, merge
            cmd      = CMD_TOG_WR;
            state_in = stat.tog_new ? S_PUSH : S_UNLINK;
         end
         S_UNLINK: begin
            cmd      = CMD_UNLINK;
            state_in = S_TOG_RD_F;
         end
         S_PUSH: begin
            cmd      = CMD_PUSH;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd          = CMD_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### hw/rtl/buddy_page_allocator.sv
// Top level of the buddy page allocator: joins controller and datapath.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ctrl, bpa_dp, assert_macros.svh.
//
//   channel  | dir | transfer when       | carries
//   req_bus  | in  | valid && ready      | action, pool_sel, block_order, page_index
//   rsp_bus  | out | valid && ready      | granted_page, status
//   csr_*    | in  | csr_we              | csr_index, csr_wdata (no read-back)
//
// One item at a time; each takes one pass through the controller sequence.
// Alloc: find and pop, then per split level a split and a pair-bit write; free: per
// merge level a pair-bit read, a write and an unlink, then a push; a rejected item
// goes straight to the result. Each level is bounded by a pair-bit RAM read then write.
// Init: a pass clearing all NUM_PAGES pair bits, then one fill per max-order block.
// After reset the same clearing pass runs before req_bus.ready rises.
// A result waits in the output register while rsp_bus.ready is low.
`include "assert_macros.svh"

module buddy_page_allocator #(
   parameter int unsigned NUM_PAGES = bpa_pkg::NUM_PAGES_DEF,
   parameter int unsigned TOP_ORDER = bpa_pkg::TOP_ORDER_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   bpa_req_if.sink                       req_bus,
   bpa_rsp_if.source                     rsp_bus,
   input  logic                          csr_we,
   input  logic [bpa_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [bpa_pkg::CFG_W-1:0]     csr_wdata
);
   import bpa_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_xfer;
   logic        rsp_fail;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bpa_dp #(.NUM_PAGES(NUM_PAGES), .TOP_ORDER(TOP_ORDER)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_action       (req_bus.action),
      .req_pool_sel     (req_bus.pool_sel),
      .req_block_order  (req_bus.block_order),
      .req_page_index   (req_bus.page_index),
      .rsp_granted_page (rsp_bus.granted_page),
      .rsp_status       (rsp_bus.status)
   );

   assign req_xfer = req_bus.valid && req_bus.ready;
   assign rsp_fail = rsp_bus.valid && (rsp_bus.status != ST_OK);

   // one item in flight: ready drops right after a transfer
   `BPA_ASSERT(a_one_in_flight, clock, reset, req_xfer |=> !req_bus.ready)
   // only defined status codes leave the block
   `BPA_ASSERT(a_status_code, clock, reset, rsp_bus.valid |-> rsp_bus.status <= ST_BAD)
   // a page is granted only with an ok status
   `BPA_ASSERT(a_page_zero_on_fail, clock, reset, rsp_fail |-> rsp_bus.granted_page == '0)
   // a result is published only from the item's last step
   `BPA_ASSERT(a_publish_once, clock, reset, (cmd == CMD_PUBLISH) |=> (rsp_bus.valid && req_bus.ready))
endmodule

### bench/bpa_checker.sv
// Checker for the buddy page allocator: watches the request, response and CSR ports,
// keeps its own copy of the free lists and pair bits, and compares every response.
// Depends on bpa_pkg, bpa_req_if and bpa_rsp_if.
module bpa_checker (
   input  logic                          clock,
   input  logic                          reset,
   bpa_req_if                            req_bus,
   bpa_rsp_if                            rsp_bus,
   input  logic                          csr_we,
   input  logic [bpa_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [bpa_pkg::CFG_W-1:0]     csr_wdata,
   output int                            errors,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int PAGES   = NUM_PAGES_DEF;
   localparam int TOP     = TOP_ORDER_DEF;
   localparam int USER_LO = TOP + 1;
   localparam int LISTS   = 2 * (TOP + 1);

   typedef struct {
      logic [PAGE_W_DEF-1:0] page;
      logic [STAT_W-1:0]     status;
   } grant_type;

   grant_type grant_q[$];

   int   total_cfg;
   int   kernel_cfg;
   int   link_nx [PAGES];
   int   link_pv [PAGES];
   int   free_head [LISTS];
   int   free_tail [LISTS];
   int   free_cnt [LISTS];
   logic pair_bit [PAGES];

   function automatic int managed_pages();
      int tb;
      tb = (total_cfg > (PAGES >> TOP)) ? (PAGES >> TOP) : total_cfg;
      return tb << TOP;
   endfunction

   function automatic int kernel_pages();
      int kp;
      kp = kernel_cfg << TOP;
      return (kp > managed_pages()) ? managed_pages() : kp;
   endfunction

   function automatic logic flip_pair(int idx, int o);
      int pos;
      pos = (PAGES - (PAGES >> o)) + (idx >> (o + 1));
      if (pos >= PAGES) return 1'b0;
      pair_bit[pos] = ~pair_bit[pos];
      return pair_bit[pos];
   endfunction

   function automatic void count_up(int l);
      if (free_cnt[l] < int'(CNT_MAX)) free_cnt[l]++;
   endfunction

   function automatic void count_down(int l);
      if (free_cnt[l] > 0) free_cnt[l]--;
   endfunction

   function automatic void append_block(int l, int n);
      if (free_cnt[l] == 0) begin
         free_head[l] = n;
      end else begin
         link_nx[free_tail[l]] = n;
         link_pv[n] = free_tail[l];
      end
      free_tail[l] = n;
      count_up(l);
   endfunction

   function automatic void prepend_block(int l, int n);
      if (free_cnt[l] == 0) begin
         free_tail[l] = n;
      end else begin
         link_pv[free_head[l]] = n;
         link_nx[n] = free_head[l];
      end
      free_head[l] = n;
      count_up(l);
   endfunction

   function automatic int take_front(int l);
      int n;
      n = free_head[l];
      free_head[l] = link_nx[n];
      count_down(l);
      return n;
   endfunction

   function automatic void detach_block(int l, int n);
      int p;
      int x;
      if (free_cnt[l] == 0) return;
      p = link_pv[n];
      x = link_nx[n];
      if (n == free_head[l]) free_head[l] = x;
      else link_nx[p] = x;
      if (n == free_tail[l]) free_tail[l] = p;
      else link_pv[x] = p;
      count_down(l);
   endfunction

   function automatic grant_type serve_request(logic [ACT_W-1:0] act, logic user, int ord,
                                               int page);
      grant_type r;
      int        base;
      int        o;
      int        idx;
      int        mask;
      r.page = '0;
      r.status = ST_OK;
      if (act == ACT_INIT) begin
         for (int i = 0; i < PAGES; i++) pair_bit[i] = 1'b0;
         for (int l = 0; l < LISTS; l++) begin
            free_head[l] = 0;
            free_tail[l] = 0;
            free_cnt[l] = 0;
         end
         for (int i = 0; i < managed_pages(); i += (1 << TOP))
            append_block(((i < kernel_pages()) ? 0 : USER_LO) + TOP, i);
      end else if (act == ACT_ALLOC) begin
         if (ord > TOP) begin
            r.status = ST_BAD;
         end else begin
            base = user ? USER_LO : 0;
            o = ord;
            while (o <= TOP && free_cnt[base + o] == 0) o++;
            if (o > TOP) begin
               r.status = ST_OOM;
            end else begin
               idx = take_front(base + o);
               if (o < TOP) void'(flip_pair(idx, o));
               // split down, upper halves go to the back of the lower lists
               while (o > ord) begin
                  o--;
                  append_block(base + o, idx + (1 << o));
                  void'(flip_pair(idx, o));
               end
               r.page = idx[PAGE_W_DEF-1:0];
            end
         end
      end else if (act == ACT_FREE) begin
         mask = (1 << ((ord > TOP) ? 0 : ord)) - 1;
         if (ord > TOP || page >= managed_pages() || (page & mask) != 0) begin
            r.status = ST_BAD;
         end else begin
            base = (page >= kernel_pages()) ? USER_LO : 0;
            idx = page;
            o = ord;
            // merge while the buddy is free
            while (o < TOP && flip_pair(idx, o) == 1'b0) begin
               detach_block(base + o, idx ^ (1 << o));
               idx &= ~(1 << o);
               o++;
            end
            prepend_block(base + o, idx);
         end
      end
      return r;
   endfunction

   task automatic report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   initial begin
      errors = 0;
      total_cfg = int'(TOTAL_RST);
      kernel_cfg = int'(KERNEL_RST);
      for (int i = 0; i < PAGES; i++) begin
         link_nx[i] = 0;
         link_pv[i] = 0;
         pair_bit[i] = 1'b0;
      end
      for (int l = 0; l < LISTS; l++) begin
         free_head[l] = 0;
         free_tail[l] = 0;
         free_cnt[l] = 0;
      end
   end

   assign pending = grant_q.size();

   always @(posedge clock) begin
      grant_type got;
      grant_type want;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_TOTAL_BLOCKS) total_cfg = int'(csr_wdata);
            else if (csr_index == CSR_KERNEL_BLOCKS) kernel_cfg = int'(csr_wdata);
         end
         if (req_bus.valid && req_bus.ready)
            grant_q.push_back(serve_request(req_bus.action, req_bus.pool_sel,
                                            int'(req_bus.block_order),
                                            int'(req_bus.page_index)));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.page = rsp_bus.granted_page;
            got.status = rsp_bus.status;
            if (grant_q.size() == 0) begin
               report($sformatf("response page %0d status %0d with nothing outstanding",
                                got.page, got.status));
            end else begin
               want = grant_q.pop_front();
               if (got.status !== want.status)
                  report($sformatf("status %0d, predicted %0d", got.status, want.status));
               if (got.page !== want.page)
                  report($sformatf("granted_page %0d, predicted %0d", got.page, want.page));
            end
         end
      end
   end
endmodule

### bench/tb_buddy_page_allocator.sv
// Testbench top for buddy_page_allocator: clock, reset, CSR phases and request traffic.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_checker and the allocator RTL.
module tb_buddy_page_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import bpa_pkg::*;

   localparam int IDLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 215;
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      int page;
      int ord;
   } held_type;

   typedef struct {
      logic [ACT_W-1:0] act;
      int               ord;
   } sent_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CFG_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;
   int   errors;
   int   pending;
   int   sent_cnt;
   int   done_cnt;
   int   idle_cycles;
   int   total_now;
   bit   calm;
   held_type live_blocks[$];
   sent_type in_flight[$];

   bpa_req_if req_bus ();
   bpa_rsp_if rsp_bus ();

   buddy_page_allocator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bpa_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side stalls in short bursts
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_bus.ready = 1'b1;
         end else if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_bus.ready = 1'b0;
            stall = $urandom_range(0, 3);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // track grants, and end the run if nothing moves
   always @(posedge clock) begin
      sent_type s;
      if (rsp_bus.valid && rsp_bus.ready) begin
         done_cnt++;
         s = in_flight.pop_front();
         if (s.act == ACT_ALLOC && rsp_bus.status == ST_OK)
            live_blocks.push_back('{int'(rsp_bus.granted_page), s.ord});
      end
      if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send(logic [ACT_W-1:0] act, logic user, int ord, int page);
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.action = act;
      req_bus.pool_sel = user;
      req_bus.block_order = ord[ORDER_W-1:0];
      req_bus.page_index = page[PAGE_W_DEF-1:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      in_flight.push_back('{act, ord});
      sent_cnt++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (done_cnt != sent_cnt) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CFG_IDX_W-1:0] idx, int val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val[CFG_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // free request that the block must reject, so no list is touched
   task automatic send_bad_free();
      int ord;
      int page;
      int mp;
      mp = ((total_now > 16) ? 16 : total_now) << TOP_ORDER_DEF;
      case ($urandom_range(0, 2))
         0: begin
            ord = $urandom_range(1, TOP_ORDER_DEF);
            page = $urandom_range(0, 16383) | (1 << $urandom_range(0, ord - 1));
         end
         1: begin
            ord = $urandom_range(0, TOP_ORDER_DEF);
            page = (mp < 16384) ? $urandom_range(mp, 16383) : $urandom_range(0, 16383);
            if (mp >= 16384) ord = $urandom_range(TOP_ORDER_DEF + 1, 15);
         end
         default: begin
            ord = $urandom_range(TOP_ORDER_DEF + 1, 15);
            page = $urandom_range(0, 16383);
         end
      endcase
      send(ACT_FREE, 1'($urandom_range(0, 1)), ord, page);
   endtask

   task automatic free_one();
      int j;
      held_type b;
      j = $urandom_range(0, live_blocks.size() - 1);
      b = live_blocks[j];
      live_blocks.delete(j);
      send(ACT_FREE, 1'($urandom_range(0, 1)), b.ord, b.page);
   endtask

   task automatic start_phase(int total, int kernel);
      drain();
      write_csr(CSR_TOTAL_BLOCKS, total);
      write_csr(CSR_KERNEL_BLOCKS, kernel);
      total_now = total;
      live_blocks.delete();
      send(ACT_INIT, 1'b0, 0, 0);
   endtask

   task automatic random_traffic(int count);
      int pick;
      int ord;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (live_blocks.size() > 300) pick = 60;
         if (pick < 45) begin
            ord = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TOP_ORDER_DEF)
                                              : $urandom_range(0, 3);
            send(ACT_ALLOC, 1'($urandom_range(0, 1)), ord, $urandom_range(0, 16383));
         end else if (pick < 85 && live_blocks.size() > 0) begin
            free_one();
         end else if (pick < 92) begin
            send_bad_free();
         end else if (pick < 96) begin
            send(ACT_ALLOC, 1'($urandom_range(0, 1)), $urandom_range(TOP_ORDER_DEF + 1, 15),
                 $urandom_range(0, 16383));
         end else begin
            send(ACT_UNUSED, 1'($urandom_range(0, 1)), $urandom_range(0, 15),
                 $urandom_range(0, 16383));
         end
      end
   endtask

   initial begin
      int tot [8];
      int ker [8];
      tot = '{16, 0, 31, 16, 16, 5, 16, 0};
      ker = '{4, 0, 31, 0, 16, 2, 31, 0};
      tot[7] = $urandom_range(1, 31);
      ker[7] = $urandom_range(0, 31);
      calm = 1'b0;
      sent_cnt = 0;
      done_cnt = 0;
      idle_cycles = 0;
      total_now = int'(TOTAL_RST);
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_INIT;
      req_bus.pool_sel = 1'b0;
      req_bus.block_order = '0;
      req_bus.page_index = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty pools, bad orders, unknown action, then split and merge
      send(ACT_ALLOC, 1'b0, 0, 0);
      send(ACT_ALLOC, 1'b1, 15, 16383);
      send(ACT_FREE, 1'b0, 11, 16383);
      send(ACT_FREE, 1'b1, 15, 0);
      send(ACT_UNUSED, 1'b1, 15, 16383);
      send(ACT_INIT, 1'b0, 0, 0);
      send(ACT_ALLOC, 1'b1, 10, 0);
      send(ACT_ALLOC, 1'b0, 0, 0);
      send(ACT_ALLOC, 1'b0, 0, 0);
      send(ACT_ALLOC, 1'b0, 3, 0);
      send(ACT_FREE, 1'b0, 3, 1);
      drain();
      // free the held blocks in grant order: buddies merge back to the top
      while (live_blocks.size() > 0) begin
         send(ACT_FREE, 1'b0, live_blocks[0].ord, live_blocks[0].page);
         void'(live_blocks.pop_front());
      end
      send(ACT_ALLOC, 1'b1, 0, 0);
      drain();
      free_one();
      for (int k = 0; k < 5; k++) send(ACT_ALLOC, 1'b0, 10, 0);

      for (int p = 0; p < 8; p++) begin
         start_phase(tot[p], ker[p]);
         if (p == 7) calm = 1'b1;
         random_traffic(PHASE_ITEMS);
      end

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
